// ===== rtl/core/adf_pkg.sv =====
package adf_pkg;

  localparam int HDR_BYTES = 7;
  localparam int LEN_W     = 13;
  localparam int CNT_W     = 3;

  // Header bit patterns
  localparam logic [7:0] SYNC_HI   = 8'hFF;
  localparam logic [3:0] SYNC_LO   = 4'hF;
  localparam logic [12:0] LEN_MIN  = 13'd7;
  localparam logic [12:0] LEN_RST  = 13'd8191;
  localparam logic [CNT_W-1:0] LAST_HDR_IDX = 3'd6;

  // Command queue
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;

  // Command opcodes
  localparam logic [1:0] OP_FRAME_HDR = 2'd0;
  localparam logic [1:0] OP_PAYLOAD   = 2'd1;
  localparam logic [1:0] OP_ERR_SYNC  = 2'd2;
  localparam logic [1:0] OP_ERR_LEN   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_BAD_SYNC = 2'd1;
  localparam logic [1:0] KIND_BAD_LEN  = 2'd2;

  typedef struct packed {
    logic        mpeg_id;
    logic        no_crc;
    logic [1:0]  profile;
    logic [3:0]  rate_index;
    logic [2:0]  channel_config;
    logic [12:0] frame_length;
    logic [10:0] buffer_fullness;
    logic [1:0]  raw_block_count;
  } fields_t;

  // One queue entry; for payload words the byte sits in hdr[0]
  typedef struct packed {
    logic [1:0]                 op;
    logic [HDR_BYTES-1:0][7:0]  hdr;
    logic                       last;
    fields_t                    fields;
  } cmd_t;

endpackage

// ===== rtl/core/adf_front.sv =====
module adf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  input  logic [7:0]      byte_data,
  input  logic            cfg_we,
  input  logic [12:0]     cfg_max_len,
  output logic            push,
  output adf_pkg::cmd_t   push_cmd
);
  import adf_pkg::*;

  logic [7:0]       hdr_store_r [0:HDR_BYTES-2];
  logic [CNT_W-1:0] hdr_count_r, hdr_count_nxt;
  logic             in_payload_r, in_payload_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  fields_t          held_r, held_nxt;
  logic [LEN_W-1:0] max_len_r;

  logic [HDR_BYTES-1:0][7:0] hdr_cur;
  fields_t dec;
  logic    sync_ok, len_ok, last_pay;

  always_comb begin
    for (int i = 0; i < HDR_BYTES - 1; i++) begin
      hdr_cur[i] = hdr_store_r[i];
    end
    hdr_cur[HDR_BYTES-1] = byte_data;
  end

  always_comb begin
    dec.mpeg_id           = hdr_cur[1][3];
    dec.no_crc            = hdr_cur[1][0];
    dec.profile           = hdr_cur[2][7:6];
    dec.rate_index        = hdr_cur[2][5:2];
    dec.channel_config    = {hdr_cur[2][0], hdr_cur[3][7:6]};
    dec.frame_length      = {hdr_cur[3][1:0], hdr_cur[4], hdr_cur[5][7:5]};
    dec.buffer_fullness   = {hdr_cur[5][4:0], hdr_cur[6][7:2]};
    dec.raw_block_count   = hdr_cur[6][1:0];
  end

  assign sync_ok  = (hdr_cur[0] == SYNC_HI) && (hdr_cur[1][7:4] == SYNC_LO);
  assign len_ok   = (dec.frame_length <= max_len_r) && (dec.frame_length >= LEN_MIN);
  assign last_pay = (bytes_left_r <= 13'd1);

  always_comb begin
    hdr_count_nxt  = hdr_count_r;
    in_payload_nxt = in_payload_r;
    bytes_left_nxt = bytes_left_r;
    held_nxt       = held_r;
    push           = 1'b0;
    push_cmd       = '0;
    if (byte_valid) begin
      if (in_payload_r) begin
        push            = 1'b1;
        push_cmd.op     = OP_PAYLOAD;
        push_cmd.hdr[0] = byte_data;
        push_cmd.last   = last_pay;
        push_cmd.fields = held_r;
        if (last_pay) begin
          in_payload_nxt = 1'b0;
          bytes_left_nxt = '0;
          hdr_count_nxt  = '0;
        end else begin
          bytes_left_nxt = bytes_left_r - 13'd1;
        end
      end else if (hdr_count_r != LAST_HDR_IDX) begin
        hdr_count_nxt = hdr_count_r + 3'd1;
      end else begin
        hdr_count_nxt = '0;
        push          = 1'b1;
        if (!sync_ok) begin
          push_cmd.op = OP_ERR_SYNC;
        end else if (!len_ok) begin
          push_cmd.op = OP_ERR_LEN;
          held_nxt    = '0;
        end else begin
          push_cmd.op     = OP_FRAME_HDR;
          push_cmd.hdr    = hdr_cur;
          push_cmd.last   = (dec.frame_length == LEN_MIN);
          push_cmd.fields = dec;
          held_nxt        = dec;
          if (dec.frame_length != LEN_MIN) begin
            in_payload_nxt = 1'b1;
            bytes_left_nxt = dec.frame_length - LEN_MIN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_count_r  <= '0;
      in_payload_r <= 1'b0;
      bytes_left_r <= '0;
      held_r       <= '0;
      max_len_r    <= LEN_RST;
    end else begin
      hdr_count_r  <= hdr_count_nxt;
      in_payload_r <= in_payload_nxt;
      bytes_left_r <= bytes_left_nxt;
      held_r       <= held_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_max_len;
      end
    end
  end

  // header bytes 0..5; byte 6 is used straight from the input
  always_ff @(posedge clk) begin
    if (byte_valid && !in_payload_r && hdr_count_r != LAST_HDR_IDX) begin
      hdr_store_r[hdr_count_r] <= byte_data;
    end
  end

endmodule

// ===== rtl/core/adf_queue.sv =====
module adf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  adf_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output adf_pkg::cmd_t  head_cmd
);
  import adf_pkg::*;

  cmd_t            mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/adf_back.sv =====
module adf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  adf_pkg::cmd_t  head_cmd,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [1:0]     res_kind,
  output logic [7:0]     res_byte,
  output logic           res_first,
  output logic           res_last,
  output adf_pkg::fields_t res_fields
);
  import adf_pkg::*;

  logic [CNT_W-1:0] k_r;
  logic             ld, done;
  logic             valid_r;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             first_r, first_nxt, last_r, last_nxt;
  fields_t          fields_r, fields_nxt;

  assign ld  = head_valid && (!valid_r || res_ready);
  assign pop = ld && done;

  always_comb begin
    done       = 1'b1;
    kind_nxt   = KIND_BYTE;
    byte_nxt   = '0;
    first_nxt  = 1'b0;
    last_nxt   = 1'b0;
    fields_nxt = '0;
    unique case (head_cmd.op)
      OP_FRAME_HDR: begin
        done       = (k_r == LAST_HDR_IDX);
        byte_nxt   = head_cmd.hdr[k_r];
        first_nxt  = (k_r == '0);
        last_nxt   = head_cmd.last && (k_r == LAST_HDR_IDX);
        fields_nxt = head_cmd.fields;
      end
      OP_PAYLOAD: begin
        byte_nxt   = head_cmd.hdr[0];
        last_nxt   = head_cmd.last;
        fields_nxt = head_cmd.fields;
      end
      OP_ERR_SYNC: kind_nxt = KIND_BAD_SYNC;
      OP_ERR_LEN:  kind_nxt = KIND_BAD_LEN;
      default:     kind_nxt = KIND_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      if (ld) begin
        k_r     <= done ? '0 : k_r + 3'd1;
        valid_r <= 1'b1;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      kind_r   <= kind_nxt;
      byte_r   <= byte_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      fields_r <= fields_nxt;
    end
  end

  assign res_valid  = valid_r;
  assign res_kind   = kind_r;
  assign res_byte   = byte_r;
  assign res_first  = first_r;
  assign res_last   = last_r;
  assign res_fields = fields_r;

endmodule

// ===== rtl/core/adts_frame_deframer.sv =====
// ADTS deframer: takes raw stream bytes one per word and sends out whole frames. Seven
// header bytes are gathered; the 0xFFF sync and a frame length in [7, max_frame_length]
// are checked. A good header is sent as seven words carrying the decoded header fields,
// the payload follows one word per byte, and tlast marks the frame's final byte. A bad
// header gives one error word (kind in tuser, everything else zero) and is dropped.
// Throughput is one byte per cycle in, one word per cycle out while out_tready is high; the
// input side stalls only when the eight-entry command queue between the header parser
// and the output sequencer is full. That depth absorbs the seven-word header burst, so
// with out_tready held high the input never stalls. Words pass through the command queue
// and the output register before they show on out_*; header and error words are queued
// as the seventh header byte is accepted. The user must write max_frame_length via
// cfg_data only while the block is idle (not enforced). cfg_ready is always high.
module adts_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_byte, mpeg_id, no_crc, profile,
                                  // rate_index, channel_config, frame_length,
                                  // buffer_fullness, raw_block_count, zero pad
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] first_of_frame
  output logic        out_tlast,  // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data    // max_frame_length
);
  import adf_pkg::*;

  logic    q_full, push, pop, head_valid;
  cmd_t    push_cmd, head_cmd;
  logic    byte_valid;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic    res_first;
  fields_t res_fields;

  assign in_tready  = !q_full;
  assign byte_valid = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  adf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_data   (in_tdata),
    .cfg_we      (cfg_valid),
    .cfg_max_len (cfg_data),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  adf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  adf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_kind   (res_kind),
    .res_byte   (res_byte),
    .res_first  (res_first),
    .res_last   (out_tlast),
    .res_fields (res_fields)
  );

  // pack from the lowest bit up
  assign out_tdata = {3'b000,
                      res_fields.raw_block_count,
                      res_fields.buffer_fullness,
                      res_fields.frame_length,
                      res_fields.channel_config,
                      res_fields.rate_index,
                      res_fields.profile,
                      res_fields.no_crc,
                      res_fields.mpeg_id,
                      res_byte};
  assign out_tuser = {res_first, res_kind};

endmodule
